// ===== rtl/msgtok_pkg.sv =====
// Shared types and constants for the message catalog tokenizer.
package msgtok_pkg;

   typedef enum logic [2:0] {
      MODE_ERROR   = 3'd0,
      MODE_IDLE    = 3'd1,
      MODE_END     = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_ATOM    = 3'd4,
      MODE_STRING  = 3'd5,
      MODE_ESCAPE  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      EV_CHAR   = 3'd0,
      EV_ATOM   = 3'd1,
      EV_STRING = 3'd2,
      EV_END    = 3'd3,
      EV_ERROR  = 3'd4
   } event_type;

   localparam int LINE_REPORT_BITS = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_HASH      = 8'd35;
   localparam logic [7:0] CH_QUOTE     = 8'd34;
   localparam logic [7:0] CH_BACKSLASH = 8'd92;
   localparam logic [7:0] CH_LOWER_N   = 8'd110;

   // One classified input item: its first result and whether an end event follows.
   typedef struct packed {
      event_type                     ev;
      logic [7:0]                    token_char;
      logic                          in_string;
      logic [LINE_REPORT_BITS-1:0]   line_number;
      logic                          two;
   } job_type;

endpackage

// ===== rtl/msgtok_front.sv =====
// Front end: scan mode and line counter, classifies each byte into a job.
module msgtok_front #(
   parameter int LINE_COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_byte,
   input  logic               end_of_input,
   output logic               job_push,
   output msgtok_pkg::job_type job
);
   import msgtok_pkg::*;

   mode_type                   mode_ff, mode_in;
   logic [LINE_COUNT_BITS-1:0] line_ff, line_in;
   logic [LINE_REPORT_BITS-1:0] line_report;
   logic                       consume, is_space, is_alpha, is_alnum, ctrl;
   logic                       emit;

   assign is_space = (text_byte == CH_SPACE) || (text_byte >= 8'd9 && text_byte <= 8'd13);
   assign is_alpha = (text_byte >= 8'd65 && text_byte <= 8'd90) ||
                     (text_byte >= 8'd97 && text_byte <= 8'd122);
   assign is_alnum = is_alpha || (text_byte >= 8'd48 && text_byte <= 8'd57);
   assign ctrl     = text_byte < CH_SPACE;
   assign consume  = (mode_ff != MODE_ERROR) && (mode_ff != MODE_END);

   always_comb begin
      line_in = line_ff;
      if (consume && !end_of_input && text_byte == CH_NEWLINE && !(&line_ff)) begin
         line_in = line_ff + 1'b1;
      end
   end

   if (LINE_COUNT_BITS > LINE_REPORT_BITS) begin : g_wide
      assign line_report = (|line_in[LINE_COUNT_BITS-1:LINE_REPORT_BITS]) ?
                           {LINE_REPORT_BITS{1'b1}} : line_in[LINE_REPORT_BITS-1:0];
   end else begin : g_narrow
      assign line_report = LINE_REPORT_BITS'(line_in);
   end

   always_comb begin
      mode_in        = mode_ff;
      emit           = 1'b0;
      job.ev         = EV_ERROR;
      job.token_char = 8'd0;
      job.in_string  = 1'b0;
      job.two        = 1'b0;
      job.line_number = line_report;
      unique case (mode_ff)
         MODE_END: begin
            emit = 1'b1;
            job.ev = EV_END;
         end
         MODE_IDLE: begin
            if (end_of_input) begin
               mode_in = MODE_END;
               emit = 1'b1;
               job.ev = EV_END;
            end else if (is_space || ctrl) begin
               mode_in = MODE_IDLE;
            end else if (text_byte == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (text_byte == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else if (!is_alpha) begin
               mode_in = MODE_ERROR;
               emit = 1'b1;
            end else begin
               mode_in = MODE_ATOM;
               emit = 1'b1;
               job.ev = EV_CHAR;
               job.token_char = text_byte;
            end
         end
         MODE_COMMENT: begin
            if (end_of_input) begin
               mode_in = MODE_END;
               emit = 1'b1;
               job.ev = EV_END;
            end else if (text_byte == CH_NEWLINE) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_ATOM: begin
            if (end_of_input) begin
               mode_in = MODE_END;
               emit = 1'b1;
               job.ev = EV_ATOM;
               job.two = 1'b1;
            end else if (is_space) begin
               mode_in = MODE_IDLE;
               emit = 1'b1;
               job.ev = EV_ATOM;
            end else if (is_alnum) begin
               emit = 1'b1;
               job.ev = EV_CHAR;
               job.token_char = text_byte;
            end else begin
               mode_in = MODE_ERROR;
               emit = 1'b1;
            end
         end
         MODE_STRING: begin
            if (end_of_input || ctrl) begin
               mode_in = MODE_ERROR;
               emit = 1'b1;
            end else if (text_byte == CH_QUOTE) begin
               mode_in = MODE_IDLE;
               emit = 1'b1;
               job.ev = EV_STRING;
            end else if (text_byte == CH_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               emit = 1'b1;
               job.ev = EV_CHAR;
               job.token_char = text_byte;
               job.in_string = 1'b1;
            end
         end
         MODE_ESCAPE: begin
            if (end_of_input || ctrl) begin
               mode_in = MODE_ERROR;
               emit = 1'b1;
            end else begin
               mode_in = MODE_STRING;
               emit = 1'b1;
               job.ev = EV_CHAR;
               job.token_char = (text_byte == CH_LOWER_N) ? CH_NEWLINE : text_byte;
               job.in_string = 1'b1;
            end
         end
         default: begin
            // Error mode is sticky, and any unused code falls into it.
            mode_in = MODE_ERROR;
            emit = 1'b1;
         end
      endcase
   end

   assign job_push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
      end
   end

endmodule

// ===== rtl/msgtok_queue.sv =====
// Short job queue between the front end and the result stage.
module msgtok_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  msgtok_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output msgtok_pkg::job_type head_job
);
   import msgtok_pkg::*;

   job_type                   mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/msgtok_back.sv =====
// Result stage: expands jobs into result items and holds them in an output register.
module msgtok_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  msgtok_pkg::job_type job,
   output logic               job_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [2:0]         rsp_event_res,
   output logic [7:0]         rsp_token_char,
   output logic               rsp_in_string,
   output logic [15:0]        rsp_line_number,
   output logic               rsp_last
);
   import msgtok_pkg::*;

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic        load;
   event_type   ev_ff, ev_in;
   logic [7:0]  char_ff, char_in;
   logic        str_ff, str_in;
   logic [15:0] line_ff, line_in;
   logic        last_ff, last_in;

   assign load = !valid_ff || rsp_pop;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      job_pop  = 1'b0;
      ev_in    = ev_ff;
      char_in  = char_ff;
      str_in   = str_ff;
      line_in  = line_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !job_empty;
         if (!job_empty) begin
            line_in = job.line_number;
            if (phase_ff) begin
               // Second result of an atom cut short by the end of input.
               ev_in    = EV_END;
               char_in  = 8'd0;
               str_in   = 1'b0;
               last_in  = 1'b1;
               phase_in = 1'b0;
               job_pop  = 1'b1;
            end else begin
               ev_in    = job.ev;
               char_in  = job.token_char;
               str_in   = job.in_string;
               last_in  = !job.two;
               phase_in = job.two;
               job_pop  = !job.two;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      char_ff <= char_in;
      str_ff  <= str_in;
      line_ff <= line_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_token_char  = char_ff;
   assign rsp_in_string   = str_ff;
   assign rsp_line_number = line_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/message_catalog_tokenizer.sv =====
// Top level of the message catalog tokenizer.
//
//   channel   direction  handshake            payload
//   req_      in         req_push / req_full  text_byte, end_of_input
//   rsp_      out        rsp_pop / rsp_empty  event_res, token_char, in_string,
//                                             line_number, last
//
// One byte is accepted per cycle while req_full is low; the front end updates the
// scan mode and line counter in the accept cycle. Results pass through the job
// queue and output register, one per cycle while rsp_pop is high; an atom cut
// short by the end of input gives two. Reset clears the mode, counter, queue and
// output register. req_full rises only when the four-entry job queue fills.
module message_catalog_tokenizer #(
   parameter int LINE_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_token_char,
   output logic        rsp_in_string,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last
);
   import msgtok_pkg::*;

   logic    accept, job_push, job_pop, q_full, q_empty;
   job_type new_job, head_job;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   msgtok_front #(
      .LINE_COUNT_BITS(LINE_COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_input(req_end_of_input),
      .job_push    (job_push),
      .job         (new_job)
   );

   msgtok_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .push_job(new_job),
      .pop     (job_pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_job(head_job)
   );

   msgtok_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (q_empty),
      .job            (head_job),
      .job_pop        (job_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_char (rsp_token_char),
      .rsp_in_string  (rsp_in_string),
      .rsp_line_number(rsp_line_number),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/msgtok_checker.sv =====
// Port-level checks for the message catalog tokenizer, bound to the top level.
module msgtok_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_token_char,
   input logic        rsp_in_string,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last
);
   import msgtok_pkg::*;

   // The output register is cleared by reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // Only an atom end can be followed by another result of the same item.
   a_not_last_is_atom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> (rsp_event_res == EV_ATOM))
      else $error("non-final result is not an atom end");

   // An atom end that is not final is followed by the end event.
   a_atom_then_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last && rsp_pop) |=> (rsp_empty || rsp_event_res == EV_END))
      else $error("atom end not followed by end event");

   // Events other than an appended character carry no character.
   a_char_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res != EV_CHAR) |-> (rsp_token_char == 8'd0 && !rsp_in_string))
      else $error("character data on a non-character event");

   // The line count never goes backward between results.
   a_line_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> (rsp_empty || rsp_line_number >= $past(rsp_line_number)))
      else $error("line number decreased");

endmodule

bind message_catalog_tokenizer msgtok_port_checks u_checker (.*);

// ===== dv/msgtok_checker.sv =====
// Checker that predicts and compares every result of the message catalog tokenizer.
`timescale 1ns / 100ps
module msgtok_checker #(
   parameter int LINE_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [2:0]  rsp_event_res,
   input  logic [7:0]  rsp_token_char,
   input  logic        rsp_in_string,
   input  logic [15:0] rsp_line_number,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);
   import msgtok_pkg::*;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  ch;
      logic        str;
      logic [15:0] line;
      logic        last;
   } token_result_type;

   token_result_type           expected_tokens[$];
   mode_type                   scan_state;
   logic [LINE_COUNT_BITS-1:0] newline_total;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // The line field reports the count as it stands, clipped to 16 bits.
   function automatic token_result_type make_result(input event_type ev, input logic [7:0] ch,
                                                    input logic str);
      token_result_type r;
      longint unsigned total;
      total = newline_total;
      r.ev = ev;
      r.ch = ch;
      r.str = str;
      r.line = (total > 64'hFFFF) ? 16'hFFFF : total[15:0];
      r.last = 1'b0;
      return r;
   endfunction

   task automatic scan_byte(input logic [7:0] c, input logic eoi);
      token_result_type res [2];
      int n;
      n = 0;
      if (scan_state == MODE_ERROR) begin
         res[n++] = make_result(EV_ERROR, 8'd0, 1'b0);
      end else if (scan_state == MODE_END) begin
         res[n++] = make_result(EV_END, 8'd0, 1'b0);
      end else begin
         if (!eoi && c == CH_NEWLINE && newline_total != '1)
            newline_total++;
         case (scan_state)
            MODE_IDLE: begin
               if (eoi) begin
                  scan_state = MODE_END;
                  res[n++] = make_result(EV_END, 8'd0, 1'b0);
               end else if (c <= CH_SPACE) begin
                  // Blanks and control bytes pass silently.
               end else if (c == CH_HASH) begin
                  scan_state = MODE_COMMENT;
               end else if (c == CH_QUOTE) begin
                  scan_state = MODE_STRING;
               end else if (!is_letter(c)) begin
                  scan_state = MODE_ERROR;
                  res[n++] = make_result(EV_ERROR, 8'd0, 1'b0);
               end else begin
                  scan_state = MODE_ATOM;
                  res[n++] = make_result(EV_CHAR, c, 1'b0);
               end
            end
            MODE_COMMENT: begin
               if (eoi) begin
                  scan_state = MODE_END;
                  res[n++] = make_result(EV_END, 8'd0, 1'b0);
               end else if (c == CH_NEWLINE) begin
                  scan_state = MODE_IDLE;
               end
            end
            MODE_ATOM: begin
               if (eoi) begin
                  scan_state = MODE_END;
                  res[n++] = make_result(EV_ATOM, 8'd0, 1'b0);
                  res[n++] = make_result(EV_END, 8'd0, 1'b0);
               end else if (is_blank(c)) begin
                  scan_state = MODE_IDLE;
                  res[n++] = make_result(EV_ATOM, 8'd0, 1'b0);
               end else if (is_letter(c) || (c >= "0" && c <= "9")) begin
                  res[n++] = make_result(EV_CHAR, c, 1'b0);
               end else begin
                  scan_state = MODE_ERROR;
                  res[n++] = make_result(EV_ERROR, 8'd0, 1'b0);
               end
            end
            MODE_STRING: begin
               if (eoi || c < CH_SPACE) begin
                  scan_state = MODE_ERROR;
                  res[n++] = make_result(EV_ERROR, 8'd0, 1'b0);
               end else if (c == CH_QUOTE) begin
                  scan_state = MODE_IDLE;
                  res[n++] = make_result(EV_STRING, 8'd0, 1'b0);
               end else if (c == CH_BACKSLASH) begin
                  scan_state = MODE_ESCAPE;
               end else begin
                  res[n++] = make_result(EV_CHAR, c, 1'b1);
               end
            end
            default: begin
               if (eoi || c < CH_SPACE) begin
                  scan_state = MODE_ERROR;
                  res[n++] = make_result(EV_ERROR, 8'd0, 1'b0);
               end else begin
                  scan_state = MODE_STRING;
                  res[n++] = make_result(EV_CHAR, (c == CH_LOWER_N) ? CH_NEWLINE : c, 1'b1);
               end
            end
         endcase
      end
      if (n > 0) begin
         res[n-1].last = 1'b1;
         for (int i = 0; i < n; i++)
            expected_tokens.push_back(res[i]);
      end
   endtask

   task automatic check_result();
      token_result_type want;
      token_result_type got;
      got.ev = event_type'(rsp_event_res);
      got.ch = rsp_token_char;
      got.str = rsp_in_string;
      got.line = rsp_line_number;
      got.last = rsp_last;
      if (expected_tokens.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected result ev %0d char %02h str %0b line %0d last %0b",
                     $time, got.ev, got.ch, got.str, got.line, got.last);
      end else begin
         want = expected_tokens.pop_front();
         if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: result mismatch, expected ev %0d char %02h str %0b line %0d last %0b",
                        $time, want.ev, want.ch, want.str, want.line, want.last);
               $display("%0t:   got ev %0d char %02h str %0b line %0d last %0b",
                        $time, got.ev, got.ch, got.str, got.line, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_state = MODE_IDLE;
         newline_total = '0;
         fail_count = 0;
         expected_tokens.delete();
      end else begin
         if (req_push && !req_full)
            scan_byte(req_text_byte, req_end_of_input);
         if (rsp_pop && !rsp_empty)
            check_result();
      end
      pending = expected_tokens.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the message catalog tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
   import msgtok_pkg::*;

   localparam int ITEM_TARGET  = 1800;
   localparam int FLOOD_LINES  = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_text_byte;
   logic        req_end_of_input;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_token_char;
   logic        rsp_in_string;
   logic [15:0] rsp_line_number;
   logic        rsp_last;

   int   fail_count;
   int   pending;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   logic gaps_on = 1'b1;
   logic stalls_on = 1'b1;
   logic [7:0] opening_text [$];

   message_catalog_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_event_res    (rsp_event_res),
      .rsp_token_char   (rsp_token_char),
      .rsp_in_string    (rsp_in_string),
      .rsp_line_number  (rsp_line_number),
      .rsp_last         (rsp_last)
   );

   msgtok_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_event_res    (rsp_event_res),
      .rsp_token_char   (rsp_token_char),
      .rsp_in_string    (rsp_in_string),
      .rsp_line_number  (rsp_line_number),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is cut short when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("message_catalog_tokenizer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: pop in random runs broken by random stalls.
   initial begin
      int hold;
      rsp_pop = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_pop <= 1'b0;
            hold = $urandom_range(0, 12);
         end else begin
            rsp_pop <= 1'b1;
            hold = stalls_on ? $urandom_range(0, 24) : 0;
         end
      end
   end

   task automatic push_item(input logic [7:0] b, input logic eoi);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_text_byte <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? "a" : "A";
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_blank();
      return $urandom_range(0, 2) == 0 ? CH_SPACE : 8'($urandom_range(9, 13));
   endfunction

   // Any byte from 32 to 255 that neither closes the string nor starts an escape.
   function automatic logic [7:0] rand_string_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
      return c;
   endfunction

   task automatic send_atom();
      push_item(rand_letter(), 1'b0);
      repeat ($urandom_range(0, 7)) begin
         if ($urandom_range(0, 2) == 0)
            push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
         else
            push_item(rand_letter(), 1'b0);
      end
      push_item(rand_blank(), 1'b0);
   endtask

   task automatic send_string();
      push_item(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 5))
            0: begin
               push_item(CH_BACKSLASH, 1'b0);
               push_item(CH_LOWER_N, 1'b0);
            end
            1: begin
               push_item(CH_BACKSLASH, 1'b0);
               push_item(8'($urandom_range(32, 255)), 1'b0);
            end
            default: push_item(rand_string_char(), 1'b0);
         endcase
      end
      push_item(CH_QUOTE, 1'b0);
   endtask

   task automatic send_comment();
      logic [7:0] c;
      push_item(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 10)) begin
         do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
         push_item(c, 1'b0);
      end
      push_item(CH_NEWLINE, 1'b0);
   endtask

   // Ends the stream with one way of reaching the end or an error; the mode then sticks.
   task automatic send_broken_tail();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: push_item(8'($urandom_range(0, 255)), 1'b1);
         1: begin
            push_item(CH_HASH, 1'b0);
            push_item(8'hFF, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1);
         end
         2: begin
            push_item(rand_letter(), 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1);
         end
         3: begin
            do c = 8'($urandom_range(33, 255));
            while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
                   || c == CH_HASH || c == CH_QUOTE);
            push_item(c, 1'b0);
         end
         4: begin
            push_item(rand_letter(), 1'b0);
            case ($urandom_range(0, 3))
               0: push_item(CH_HASH, 1'b0);
               1: push_item(8'hFF, 1'b0);
               2: push_item(8'h01, 1'b0);
               default: push_item(CH_QUOTE, 1'b0);
            endcase
         end
         5: begin
            push_item(CH_QUOTE, 1'b0);
            push_item(rand_string_char(), 1'b0);
            push_item(8'($urandom_range(0, 31)), 1'b0);
         end
         6: begin
            push_item(CH_QUOTE, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            push_item(CH_QUOTE, 1'b0);
            push_item(CH_BACKSLASH, 1'b0);
            if ($urandom_range(0, 1))
               push_item(8'($urandom_range(0, 255)), 1'b1);
            else
               push_item(8'($urandom_range(0, 31)), 1'b0);
         end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_text_byte = 8'd0;
      req_end_of_input = 1'b0;
      opening_text = '{8'h00, 8'h09, CH_SPACE, CH_HASH, 8'hFF, 8'h80, CH_NEWLINE,
                       "Z", "0", "9", "z", CH_SPACE,
                       CH_QUOTE, 8'hFF, CH_BACKSLASH, CH_LOWER_N, CH_BACKSLASH, 8'h7F,
                       CH_BACKSLASH, CH_QUOTE, CH_SPACE, CH_QUOTE,
                       "A", CH_NEWLINE, 8'h1F};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_text[i])
         push_item(opening_text[i], 1'b0);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_atom();
            3, 4, 5: send_string();
            6: send_comment();
            default: begin
               repeat ($urandom_range(1, 3))
                  push_item(8'($urandom_range(0, 32)), 1'b0);
            end
         endcase
      end

      // Full rate from here on: a burst of newlines, then close.
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      repeat (FLOOD_LINES) push_item(CH_NEWLINE, 1'b0);
      send_atom();
      send_string();
      send_broken_tail();
      repeat (6) push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_push <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("message_catalog_tokenizer verification clean");
      else
         $display("message_catalog_tokenizer verification failed");
      $finish;
   end

endmodule
